@@ rtl/core/b2a_pkg.sv @@
// b2a_pkg: types, constants and the digit-to-ascii function for binary_to_ascii_digits
// no dependencies
`timescale 1ns / 1ps

package b2a_pkg;

    localparam int VALUE_W        = 64;
    localparam int KIND_W         = 1;
    localparam int CHAR_W         = 7;
    localparam int DIGIT_W        = 4;
    localparam int MAX_DIGITS_DEF = 20;
    localparam int BIT_CNT_W      = $clog2(VALUE_W);

    localparam logic [KIND_W-1:0]  KIND_DEC = 1'b0;
    localparam logic [KIND_W-1:0]  KIND_HEX = 1'b1;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_NINE  = 7'd57;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER_F = 7'd70;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

    function automatic logic [CHAR_W-1:0] f_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_UPPER_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

@@ rtl/core/binary_to_ascii_digits.sv @@
// binary_to_ascii_digits: 64-bit unsigned value to ascii decimal or hex digits, msd first
// depends on b2a_pkg
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+---------------------------
//   input   | in        | i_valid / o_stall | i_value[63:0], i_kind
//   output  | out       | o_valid / i_stall | o_digit_char[6:0], o_last
//
// one shift-and-add-3 unit shifts in all 64 bits of a word (hex mode shifts without adjust)
// then drops leading zero digits, then sends the digits one by one
// o_stall is high from the accept until the last digit sits in the output register
// i_rst_n is synchronous, active low; it clears the sequencer and the output valid
`timescale 1ns / 1ps

module binary_to_ascii_digits #(
    parameter int MAX_DIGITS = b2a_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [b2a_pkg::VALUE_W-1:0]   i_value,
    input  logic [b2a_pkg::KIND_W-1:0]    i_kind,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [b2a_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                          o_last
);
    import b2a_pkg::*;

    localparam int STORE_W = MAX_DIGITS * DIGIT_W;
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);

    t_state               r_state, n_state;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [STORE_W-1:0]   r_digits, n_digits;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic                 r_ovf, n_ovf;
    logic [BIT_CNT_W-1:0] r_bit, n_bit;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;

    logic [STORE_W-1:0]   adj;
    logic [DIGIT_W-1:0]   top_digit;
    logic                 out_free;

    // add 3 to every decimal digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_kind == KIND_DEC && r_digits[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adj[i*DIGIT_W +: DIGIT_W] = r_digits[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                adj[i*DIGIT_W +: DIGIT_W] = r_digits[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign top_digit = r_digits[STORE_W-1 -: DIGIT_W];
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_digits    = r_digits;
        n_kind      = r_kind;
        n_ovf       = r_ovf;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_value  = i_value;
                    n_kind   = i_kind;
                    n_digits = '0;
                    n_ovf    = 1'b0;
                    n_bit    = '0;
                    n_state  = S_CONV;
                end
            end
            S_CONV: begin
                n_digits = {adj[STORE_W-2:0], r_value[VALUE_W-1]};
                n_ovf    = r_ovf | adj[STORE_W-1];
                n_value  = {r_value[VALUE_W-2:0], 1'b0};
                n_bit    = r_bit + BIT_CNT_W'(1);
                if (r_bit == BIT_CNT_W'(VALUE_W - 1)) begin
                    n_cnt   = CNT_W'(MAX_DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keeping at least one digit, unless high digits were lost off the top
                if (!r_ovf && top_digit == '0 && r_cnt > CNT_W'(1)) begin
                    n_digits = {r_digits[STORE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_cnt    = r_cnt - CNT_W'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = f_ascii(top_digit);
                    n_out_last  = (r_cnt == CNT_W'(1));
                    n_digits    = {r_digits[STORE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_cnt       = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_bit       <= '0;
            r_cnt       <= '0;
            r_value     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bit       <= n_bit;
            r_cnt       <= n_cnt;
            r_value     <= n_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits   <= n_digits;
        r_kind     <= n_kind;
        r_ovf      <= n_ovf;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last       = r_out_last;

endmodule

@@ rtl/core/b2a_checker.sv @@
// b2a_checker: port-level assertions, bound into every binary_to_ascii_digits instance
// depends on b2a_pkg and binary_to_ascii_digits
`timescale 1ns / 1ps

module b2a_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [b2a_pkg::CHAR_W-1:0]    o_digit_char,
    input logic                          o_last
);
    import b2a_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_digit_char) && $stable(o_last)))
        else $error("output word changed while stalled");

    // only digit and upper-case hex codes come out
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_digit_char >= CHAR_ZERO && o_digit_char <= CHAR_NINE) ||
                     (o_digit_char >= CHAR_UPPER_A && o_digit_char <= CHAR_UPPER_F)))
        else $error("illegal digit character");

    // an accepted word makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accept");

    // a word is not converted at once, so no output right after an idle accept
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !o_valid) |=> !o_valid)
        else $error("output appeared before conversion");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind binary_to_ascii_digits b2a_checker u_b2a_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_digit_char (o_digit_char),
    .o_last       (o_last)
);
